### hw/rtl/afsk_pkg.sv
// shared types, constants and sine table function for the afsk tone modulator
package afsk_pkg;

   localparam int unsigned PHASE_W     = 32;
   localparam int unsigned RATE_W      = 18;
   localparam int unsigned AMP_W       = 16;
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam int unsigned DEF_SINE_ENTRIES = 1024;
   localparam int unsigned DEF_MAX_SAMPLES  = 64;

   localparam logic [PHASE_W-1:0] RST_MARK_STEP   = 32'd116869860;
   localparam logic [PHASE_W-1:0] RST_SPACE_STEP  = 32'd214261406;
   localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE = 18'd44100;
   localparam logic [RATE_W-1:0]  RST_BIT_RATE    = 18'd1200;
   localparam logic [AMP_W-1:0]   RST_AMPLITUDE   = 16'd32768;

   localparam longint unsigned SIN_C1  = 64'd1686629713;
   localparam longint unsigned SIN_C3  = 64'd693598668;
   localparam longint unsigned SIN_C5  = 64'd85569306;
   localparam longint unsigned SIN_C7  = 64'd5026995;
   localparam longint unsigned SIN_C9  = 64'd172272;
   localparam longint unsigned Q30_ONE = 64'd1073741824;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MARK_STEP   = 3'd0,
      CSR_SPACE_STEP  = 3'd1,
      CSR_SAMPLE_RATE = 3'd2,
      CSR_BIT_RATE    = 3'd3,
      CSR_AMPLITUDE   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start_bit;
      logic issue;
      logic issue_silent;
      logic mod_step;
   } cmd_type;

   typedef struct packed {
      logic can_issue;
      logic no_samples;
      logic last;
      logic overrun;
      logic mod_last;
   } status_type;

   // q1.15 sine entry k of a table with 2**idx_w entries
   function automatic logic [SAMPLE_W-1:0] sine_value(input longint unsigned k,
                                                      input int unsigned idx_w);
      longint unsigned t;
      longint unsigned q;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned p;
      longint unsigned s;
      longint unsigned e;
      t = k << (PHASE_W - idx_w);
      q = (t >> 30) & 64'd3;
      x = t & (Q30_ONE - 64'd1);
      if (q[0]) begin
         x = Q30_ONE - x;
      end
      x2 = (x * x) >> 30;
      p = SIN_C9;
      p = SIN_C7 - ((p * x2) >> 30);
      p = SIN_C5 - ((p * x2) >> 30);
      p = SIN_C3 - ((p * x2) >> 30);
      p = SIN_C1 - ((p * x2) >> 30);
      s = (p * x) >> 30;
      e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      if (q >= 64'd2) begin
         e = 64'd0 - e;
      end
      return SAMPLE_W'(e);
   endfunction

endpackage

### hw/rtl/afsk_tone_modulator.sv
// top level of the phase-continuous afsk tone modulator
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_func, req_level
//   rsp      out        rsp_valid/rsp_ready    rsp_sample, rsp_last, rsp_overrun
//   csr      in         csr_write              csr_index, csr_data
//
// a silence word issues a single silent sample; a data bit issues one sample per cycle while the output queue has room,
// as the block has a single phase accumulator and sine table port
// a bit whose sample count exceeds the cap is followed by a serial remainder reduction
// each sample passes the table read, scaling and queue write stages before it appears
// reset restores register defaults and clears phase and remainder
// the output queue holds four samples; issue pauses while it is full
module afsk_tone_modulator #(
   parameter int unsigned SineEntries      = afsk_pkg::DEF_SINE_ENTRIES,
   parameter int unsigned MaxSamplesPerBit = afsk_pkg::DEF_MAX_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [afsk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [afsk_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_func,
   input  logic                                 req_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [afsk_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_last,
   output logic                                 rsp_overrun
);
   import afsk_pkg::*;

   cmd_type    cmd;
   status_type status;

   afsk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func (req_func),
      .status   (status),
      .cmd      (cmd)
   );

   afsk_datapath #(
      .SineEntries     (SineEntries),
      .MaxSamplesPerBit(MaxSamplesPerBit)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_level  (req_level),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last),
      .rsp_overrun(rsp_overrun)
   );

endmodule

### hw/rtl/afsk_sine_rom.sv
// sine lookup table with registered read
module afsk_sine_rom #(
   parameter int unsigned SineEntries = afsk_pkg::DEF_SINE_ENTRIES
) (
   input  logic                                clock,
   input  logic [$clog2(SineEntries)-1:0]      rd_addr,
   output logic [afsk_pkg::SAMPLE_W-1:0]       rd_data
);
   import afsk_pkg::*;

   localparam int unsigned IdxW = $clog2(SineEntries);

   typedef logic [SAMPLE_W-1:0] rom_type [SineEntries];

   function automatic rom_type build_rom();
      rom_type r;
      for (int k = 0; k < SineEntries; k++) begin
         r[k] = sine_value(longint'(k), IdxW);
      end
      return r;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= SineRom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/afsk_datapath.sv
// registers, remainder arithmetic, phase accumulator, sample pipeline and output queue
module afsk_datapath #(
   parameter int unsigned SineEntries      = afsk_pkg::DEF_SINE_ENTRIES,
   parameter int unsigned MaxSamplesPerBit = afsk_pkg::DEF_MAX_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [afsk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [afsk_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 req_level,
   input  afsk_pkg::cmd_type                    cmd,
   output afsk_pkg::status_type                 status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [afsk_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                 rsp_last,
   output logic                                 rsp_overrun
);
   import afsk_pkg::*;

   localparam int unsigned IdxW    = $clog2(SineEntries);
   localparam int unsigned CntW    = $clog2(MaxSamplesPerBit);
   localparam int unsigned TotW    = RATE_W + 1;
   localparam int unsigned CapW    = RATE_W + $clog2(MaxSamplesPerBit + 2);
   localparam int unsigned ModCntW = $clog2(TotW);
   localparam int unsigned PtrW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned OccW    = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MagW    = SAMPLE_W - 1;
   localparam int unsigned ProdW   = MagW + AMP_W;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                overrun;
   } entry_type;

   // configuration
   logic [PHASE_W-1:0] mark_step_ff;
   logic [PHASE_W-1:0] space_step_ff;
   logic [RATE_W-1:0]  sample_rate_ff;
   logic [RATE_W-1:0]  bit_rate_ff;
   logic [AMP_W-1:0]   amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_step_ff   <= RST_MARK_STEP;
         space_step_ff  <= RST_SPACE_STEP;
         sample_rate_ff <= RST_SAMPLE_RATE;
         bit_rate_ff    <= RST_BIT_RATE;
         amplitude_ff   <= RST_AMPLITUDE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MARK_STEP:   mark_step_ff   <= csr_data;
            CSR_SPACE_STEP:  space_step_ff  <= csr_data;
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_data[RATE_W-1:0];
            CSR_BIT_RATE:    bit_rate_ff    <= csr_data[RATE_W-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // samples-per-bit bookkeeping
   logic [PHASE_W-1:0] tone_phase_ff;
   logic [RATE_W-1:0]  bit_remainder_ff;
   logic [TotW-1:0]    rem_ff;
   logic [PHASE_W-1:0] step_ff;
   logic               ovr_ff;
   logic [CntW-1:0]    cnt_ff;

   logic [RATE_W-1:0] div;
   logic [TotW-1:0]   total;
   logic [CapW-1:0]   cap;
   logic [TotW-1:0]   rem_next;
   logic              no_samples;
   logic              bit_ovr;
   logic              last_in;
   logic              issue_any;

   assign div        = (bit_rate_ff == '0) ? RATE_W'(1) : bit_rate_ff;
   assign total      = TotW'(bit_remainder_ff) + TotW'(sample_rate_ff);
   assign cap        = CapW'(div) * CapW'(MaxSamplesPerBit + 1);
   assign no_samples = total < TotW'(div);
   assign bit_ovr    = CapW'(total) >= cap;
   assign rem_next   = rem_ff - TotW'(div);
   assign last_in    = (rem_next < TotW'(div)) || (cnt_ff == CntW'(MaxSamplesPerBit - 1));
   assign issue_any  = cmd.issue | cmd.issue_silent;

   always_ff @(posedge clock) begin
      if (cmd.start_bit) begin
         rem_ff  <= total;
         step_ff <= req_level ? mark_step_ff : space_step_ff;
         ovr_ff  <= bit_ovr;
         cnt_ff  <= '0;
      end else if (cmd.issue) begin
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff + CntW'(1);
      end
   end

   // remainder reduction after an overrun, one quotient bit a cycle
   logic [TotW-1:0]    mod_dvd_ff;
   logic [RATE_W-1:0]  mod_r_ff;
   logic [ModCntW-1:0] mod_cnt_ff;
   logic [RATE_W:0]    mod_shift;
   logic [RATE_W-1:0]  mod_r_in;
   logic               mod_last;

   assign mod_shift = {mod_r_ff, mod_dvd_ff[TotW-1]};
   assign mod_r_in  = (mod_shift >= {1'b0, div}) ? RATE_W'(mod_shift - {1'b0, div})
                                                 : RATE_W'(mod_shift);
   assign mod_last  = mod_cnt_ff == ModCntW'(TotW - 1);

   always_ff @(posedge clock) begin
      if (cmd.issue && last_in && ovr_ff) begin
         mod_dvd_ff <= rem_next;
         mod_r_ff   <= '0;
         mod_cnt_ff <= '0;
      end else if (cmd.mod_step) begin
         mod_dvd_ff <= {mod_dvd_ff[TotW-2:0], 1'b0};
         mod_r_ff   <= mod_r_in;
         mod_cnt_ff <= mod_cnt_ff + ModCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_phase_ff    <= '0;
         bit_remainder_ff <= '0;
      end else begin
         if (cmd.issue) begin
            tone_phase_ff <= tone_phase_ff + step_ff;
         end
         if (cmd.start_bit && no_samples) begin
            bit_remainder_ff <= total[RATE_W-1:0];
         end else if (cmd.issue && last_in && !ovr_ff) begin
            bit_remainder_ff <= rem_next[RATE_W-1:0];
         end else if (cmd.mod_step && mod_last) begin
            bit_remainder_ff <= mod_r_in;
         end
      end
   end

   // sample pipeline: table read, amplitude scaling, queue write
   logic [SAMPLE_W-1:0] rom_data;

   afsk_sine_rom #(
      .SineEntries(SineEntries)
   ) u_rom (
      .clock  (clock),
      .rd_addr(tone_phase_ff[PHASE_W-1 -: IdxW]),
      .rd_data(rom_data)
   );

   logic            a_valid_ff;
   logic            a_silent_ff;
   logic            a_last_ff;
   logic            a_ovr_ff;
   logic            b_valid_ff;
   logic [MagW-1:0] b_mag_ff;
   logic            b_neg_ff;
   logic            b_last_ff;
   logic            b_ovr_ff;

   logic [SAMPLE_W-1:0] abs_e;
   logic [ProdW-1:0]    prod;
   logic [SAMPLE_W-1:0] b_sample;

   assign abs_e    = rom_data[SAMPLE_W-1] ? SAMPLE_W'(-rom_data) : rom_data;
   assign prod     = ProdW'(abs_e[MagW-1:0]) * ProdW'(amplitude_ff);
   assign b_sample = b_neg_ff ? SAMPLE_W'(-{1'b0, b_mag_ff}) : {1'b0, b_mag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= issue_any;
         b_valid_ff <= a_valid_ff;
      end
      if (issue_any) begin
         a_silent_ff <= cmd.issue_silent;
         a_last_ff   <= cmd.issue_silent | last_in;
         a_ovr_ff    <= !cmd.issue_silent & ovr_ff;
      end
      b_mag_ff  <= a_silent_ff ? '0 : prod[ProdW-1 -: MagW];
      b_neg_ff  <= !a_silent_ff & rom_data[SAMPLE_W-1];
      b_last_ff <= a_last_ff;
      b_ovr_ff  <= a_ovr_ff;
   end

   // output queue, space reserved at issue time
   entry_type       q_mem [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [OccW-1:0] q_count_ff;
   logic [OccW-1:0] occ_ff;
   logic [OccW-1:0] q_count_in;
   logic [OccW-1:0] occ_in;
   logic            pop;
   entry_type       head;

   assign pop        = rsp_valid & rsp_ready;
   assign q_count_in = q_count_ff + OccW'(b_valid_ff) - OccW'(pop);
   assign occ_in     = occ_ff + OccW'(issue_any) - OccW'(pop);

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         q_mem[wr_ptr_ff] <= '{sample: b_sample, last: b_last_ff, overrun: b_ovr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
         occ_ff     <= '0;
      end else begin
         if (b_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         end
         q_count_ff <= q_count_in;
         occ_ff     <= occ_in;
      end
   end

   assign head        = q_mem[rd_ptr_ff];
   assign rsp_valid   = q_count_ff != '0;
   assign rsp_sample  = head.sample;
   assign rsp_last    = head.last;
   assign rsp_overrun = head.overrun;

   assign status.can_issue  = occ_ff < OccW'(QUEUE_DEPTH);
   assign status.no_samples = no_samples;
   assign status.last       = last_in;
   assign status.overrun    = ovr_ff;
   assign status.mod_last   = mod_last;

endmodule

### hw/rtl/afsk_ctrl.sv
// controller state machine: word acceptance, sample issue, remainder reduction
module afsk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  afsk_pkg::status_type status,
   output afsk_pkg::cmd_type    cmd
);
   import afsk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_MOD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid & req_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = status.can_issue;
            if (accept) begin
               if (req_func) begin
                  cmd.issue_silent = 1'b1;
               end else begin
                  cmd.start_bit = 1'b1;
                  if (!status.no_samples) begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            cmd.issue = status.can_issue;
            if (status.can_issue && status.last) begin
               state_in = status.overrun ? ST_MOD : ST_IDLE;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
